// ===== rtl/core/circular_double_ended_queue_assert.svh =====
// Assertion macros for the circular deque.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CDEQ_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque check failed");

// Next-cycle implication, checked outside reset.
`define CDEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

// ===== rtl/core/cdeq_pkg.sv =====
package cdeq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int MODE_W = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_READ_FRONT = 3'd4,
    MODE_READ_BACK  = 3'd5,
    MODE_READ_AT    = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_BAD_POS = 2'd3
  } status_t;

  // Outcome of one operation, from the control unit to the result stage.
  typedef struct packed {
    status_t status;
    logic    rd_ok;
  } op_res_t;

endpackage

// ===== rtl/core/cdeq_in_if.sv =====
interface cdeq_in_if;
  logic                            valid;
  logic                            ready;
  logic [cdeq_pkg::MODE_W-1:0]     mode;
  logic signed [cdeq_pkg::VALUE_W-1:0] value;
  logic [cdeq_pkg::POS_W-1:0]      position;

  modport source (output valid, output mode, output value, output position, input ready);
  modport sink (input valid, input mode, input value, input position, output ready);
endinterface

// ===== rtl/core/cdeq_out_if.sv =====
interface cdeq_out_if #(
  parameter int CNT_W = $clog2(cdeq_pkg::CAPACITY_DEF + 1)
);
  logic                                valid;
  logic                                ready;
  logic signed [cdeq_pkg::VALUE_W-1:0] read_value;
  logic [1:0]                          status;
  logic [CNT_W-1:0]                    count;

  modport source (output valid, output read_value, output status, output count, input ready);
  modport sink (input valid, input read_value, input status, input count, output ready);
endinterface

// ===== rtl/core/circular_double_ended_queue.sv =====
// A command passes through the stage-1 register (with the store read) and then the result register.
// Throughput: one command per cycle while results are taken; the store is touched at most once per command
// (one write for a push, one read for a read, none for a pop), so its single port sets the pace.
// The result register frees the command side while a result waits to be taken.
// Reset (rst, synchronous): queue empty, front index zero; store contents stay undefined.
module circular_double_ended_queue #(
  parameter int CAPACITY = cdeq_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  cdeq_in_if.sink     cmd,
  cdeq_out_if.source  rsp
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic                         accept;
  logic                         s1_valid;
  logic                         s1_adv;
  cdeq_pkg::op_res_t            s1_res;
  logic [CNT_W-1:0]             s1_count;
  logic                         mem_we;
  logic                         mem_re;
  logic [IDX_W-1:0]             mem_addr;
  logic [cdeq_pkg::VALUE_W-1:0] mem_rdata;
  cdeq_pkg::op_res_t            ctrl_res;
  logic [CNT_W-1:0]             count_next;

  assign s1_adv    = s1_valid && (!rsp.valid || rsp.ready);
  assign cmd.ready = !s1_valid || s1_adv;
  assign accept    = cmd.valid && cmd.ready;

  cdeq_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .mode       (cmd.mode),
    .position   (cmd.position),
    .mem_we     (mem_we),
    .mem_re     (mem_re),
    .mem_addr   (mem_addr),
    .res        (ctrl_res),
    .count_next (count_next)
  );

  cdeq_store #(
    .DEPTH (CAPACITY),
    .AW    (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (accept && mem_we),
    .re    (accept && mem_re),
    .addr  (mem_addr),
    .wdata (cmd.value),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res   <= ctrl_res;
      s1_count <= count_next;
    end
    // store read data is ready in the cycle after the command transfer
    if (s1_adv) begin
      rsp.read_value <= s1_res.rd_ok ? mem_rdata : '0;
      rsp.status     <= s1_res.status;
      rsp.count      <= s1_count;
    end
  end

`include "circular_double_ended_queue_assert.svh"

  `CDEQ_ASSERT_SAME(a_count_bound, clk, rst, s1_valid, s1_count <= CAP_CNT)
  `CDEQ_ASSERT_SAME(a_write_ok, clk, rst, accept && mem_we, ctrl_res.status == cdeq_pkg::ST_OK)
  `CDEQ_ASSERT_SAME(a_read_ok, clk, rst, s1_valid && s1_res.rd_ok, s1_res.status == cdeq_pkg::ST_OK)
  `CDEQ_ASSERT_NEXT(a_rdata_hold, clk, rst, s1_valid && s1_res.rd_ok && !s1_adv, $stable(mem_rdata))

endmodule

// ===== rtl/core/cdeq_store.sv =====
module cdeq_store #(
  parameter int DEPTH = cdeq_pkg::CAPACITY_DEF,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic                         re,
  input  logic [AW-1:0]                addr,
  input  logic [cdeq_pkg::VALUE_W-1:0] wdata,
  output logic [cdeq_pkg::VALUE_W-1:0] rdata
);

  logic [cdeq_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/core/cdeq_ctrl.sv =====
module cdeq_ctrl #(
  parameter int CAPACITY = cdeq_pkg::CAPACITY_DEF,
  parameter int IDX_W = $clog2(CAPACITY),
  parameter int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [cdeq_pkg::MODE_W-1:0] mode,
  input  logic [cdeq_pkg::POS_W-1:0]  position,
  output logic                        mem_we,
  output logic                        mem_re,
  output logic [IDX_W-1:0]            mem_addr,
  output cdeq_pkg::op_res_t           res,
  output logic [CNT_W-1:0]            count_next
);

  localparam int CMP_W = (CNT_W > cdeq_pkg::POS_W) ? CNT_W : cdeq_pkg::POS_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [IDX_W-1:0] front;
  logic [IDX_W-1:0] front_next;
  logic [CNT_W-1:0] count;
  logic             empty;
  logic             full;
  logic [IDX_W-1:0] back_slot;
  logic [IDX_W-1:0] last_slot;
  logic [IDX_W-1:0] pos_slot;

  assign empty     = (count == '0);
  assign full      = (count == CAP_CNT);
  assign back_slot = front + IDX_W'(count);
  assign last_slot = back_slot - IDX_W'(1);
  assign pos_slot  = front + IDX_W'(position);

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (accept) begin
      front <= front_next;
      count <= count_next;
    end
  end

  always_comb begin
    front_next = front;
    count_next = count;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = front;
    res.status = cdeq_pkg::ST_OK;
    res.rd_ok  = 1'b0;
    case (mode)
      cdeq_pkg::MODE_PUSH_FRONT: begin
        if (full) begin
          res.status = cdeq_pkg::ST_FULL;
        end else begin
          front_next = front - IDX_W'(1);
          count_next = count + CNT_W'(1);
          mem_we     = 1'b1;
          mem_addr   = front - IDX_W'(1);
        end
      end
      cdeq_pkg::MODE_PUSH_BACK: begin
        if (full) begin
          res.status = cdeq_pkg::ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
          mem_we     = 1'b1;
          mem_addr   = back_slot;
        end
      end
      cdeq_pkg::MODE_POP_FRONT: begin
        if (empty) begin
          res.status = cdeq_pkg::ST_EMPTY;
        end else begin
          front_next = front + IDX_W'(1);
          count_next = count - CNT_W'(1);
        end
      end
      cdeq_pkg::MODE_POP_BACK: begin
        if (empty) begin
          res.status = cdeq_pkg::ST_EMPTY;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      cdeq_pkg::MODE_READ_FRONT: begin
        if (empty) begin
          res.status = cdeq_pkg::ST_EMPTY;
        end else begin
          mem_re    = 1'b1;
          res.rd_ok = 1'b1;
        end
      end
      cdeq_pkg::MODE_READ_BACK: begin
        if (empty) begin
          res.status = cdeq_pkg::ST_EMPTY;
        end else begin
          mem_re    = 1'b1;
          mem_addr  = last_slot;
          res.rd_ok = 1'b1;
        end
      end
      cdeq_pkg::MODE_READ_AT: begin
        if (empty) begin
          res.status = cdeq_pkg::ST_EMPTY;
        end else if (CMP_W'(position) >= CMP_W'(count)) begin
          res.status = cdeq_pkg::ST_BAD_POS;
        end else begin
          mem_re    = 1'b1;
          mem_addr  = pos_slot;
          res.rd_ok = 1'b1;
        end
      end
      default: begin
        // unused code: no change, ok status
      end
    endcase
  end

endmodule
